// File: rtl/lcdseq_pkg.sv
// Shared types, constants and the power-up pin table for the character LCD bus sequencer.
package lcdseq_pkg;

  // Request codes.
  localparam logic [1:0] CMD_INIT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_CURSOR = 2'd2;
  localparam logic [1:0] CMD_WRITE  = 2'd3;

  // LCD command bytes.
  localparam logic [7:0] LCD_FUNC_SET  = 8'h28;
  localparam logic [7:0] LCD_DISP_ON   = 8'h0C;
  localparam logic [7:0] LCD_ENTRY     = 8'h06;
  localparam logic [7:0] LCD_CLR_DISP  = 8'h01;
  localparam logic [7:0] LCD_SET_DDRAM = 8'h80;

  // Wake-up nibbles.
  localparam logic [3:0] WAKE_NIB_A = 4'h3;
  localparam logic [3:0] WAKE_NIB_B = 4'h2;

  // Hold times in milliseconds.
  localparam logic [5:0] HOLD_PULSE   = 6'd1;
  localparam logic [5:0] HOLD_POWERUP = 6'd50;
  localparam logic [5:0] HOLD_WAKE1   = 6'd6;
  localparam logic [5:0] HOLD_WAKE    = 6'd2;
  localparam logic [5:0] HOLD_CMD     = 6'd3;
  localparam logic [5:0] HOLD_CLEAR   = 6'd5;
  localparam logic [5:0] HOLD_DATA    = 6'd2;

  // Power-up run: steps 0 to 24, byte commands start at step 9.
  localparam logic [4:0] INIT_LAST_STEP = 5'd24;
  localparam logic [4:0] INIT_BYTE_STEP = 5'd9;
  localparam logic [4:0] INIT_WAKE_LAST = 5'd8;

  // One queued job: either the power-up run or a single byte.
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] data;
    logic [5:0] final_hold;
  } job_t;

  // One pin state as shown on the output.
  typedef struct packed {
    logic       rs;
    logic       en;
    logic [3:0] nibble;
    logic [5:0] hold;
    logic       last;
  } pin_t;

  // DDRAM offset of the first column of a row.
  function automatic logic [7:0] row_base(input logic [1:0] r);
    logic [7:0] b;
    case (r)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h40;
      2'd2:    b = 8'h14;
      default: b = 8'h54;
    endcase
    return b;
  endfunction

  // Pin state of the power-up run for steps 1 to 24 (step 0 depends on line state).
  function automatic pin_t init_pin(input logic [4:0] step);
    pin_t       p;
    logic [4:0] t;
    logic [7:0] b;
    p = '0;
    t = step - INIT_BYTE_STEP;
    b = LCD_CLR_DISP;
    p.rs = 1'b0;
    p.last = (step == INIT_LAST_STEP);
    if (step <= INIT_WAKE_LAST) begin
      // Wake-up nibbles, each as an enable pulse and a settle state.
      p.nibble = (step >= 5'd7) ? WAKE_NIB_B : WAKE_NIB_A;
      p.en = step[0];
      if (step[0]) begin
        p.hold = HOLD_PULSE;
      end else if (step == 5'd2) begin
        p.hold = HOLD_WAKE1;
      end else begin
        p.hold = HOLD_WAKE;
      end
    end else begin
      // Configuration bytes, high nibble first.
      case (t[3:2])
        2'd0:    b = LCD_FUNC_SET;
        2'd1:    b = LCD_DISP_ON;
        2'd2:    b = LCD_ENTRY;
        default: b = LCD_CLR_DISP;
      endcase
      p.nibble = t[1] ? b[3:0] : b[7:4];
      p.en = ~t[0];
      if (t[1:0] == 2'd3) begin
        p.hold = (t[3:2] == 2'd3) ? HOLD_CLEAR : HOLD_CMD;
      end else begin
        p.hold = HOLD_PULSE;
      end
    end
    return p;
  endfunction

endpackage

// File: rtl/char_lcd_4bit_bus_sequencer_unit.sv
// Top level of the 4-bit character LCD bus sequencer.
// The first pin state of a request passes through the job queue, the job register and
// the output register. The sequencer gives one pin state per cycle while the output is
// not stalled; a request yields 4 states (25 for initialise).
// A two-entry job queue lets requests be accepted while earlier ones are still sequenced.
// Reset clears the queue, the sequencer and the tracked RS and data line levels to zero.
module char_lcd_4bit_bus_sequencer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] character_i,
  input  logic [7:0] column_i,
  input  logic [7:0] row_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       rs_o,
  output logic       en_o,
  output logic [3:0] nibble_o,
  output logic [5:0] hold_ms_o,
  output logic       last_o
);

  lcdseq_pkg::job_t front_job;
  lcdseq_pkg::job_t queue_job;
  lcdseq_pkg::pin_t pin;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic             push;

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  lcdseq_front u_front (
    .cmd_i       (cmd_i),
    .character_i (character_i),
    .column_i    (column_i),
    .row_i       (row_i),
    .job_o       (front_job)
  );

  lcdseq_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (queue_job)
  );

  lcdseq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (queue_job),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pin_o       (pin)
  );

  assign rs_o      = pin.rs;
  assign en_o      = pin.en;
  assign nibble_o  = pin.nibble;
  assign hold_ms_o = pin.hold;
  assign last_o    = pin.last;

endmodule

// File: rtl/lcdseq_front.sv
// Front end: decodes a request into a queued job.
module lcdseq_front (
  input  logic              [1:0] cmd_i,
  input  logic              [7:0] character_i,
  input  logic              [7:0] column_i,
  input  logic              [7:0] row_i,
  output lcdseq_pkg::job_t        job_o
);

  logic [1:0] row_sel;
  logic [7:0] addr;

  // A row past the last display line falls back to the first line.
  assign row_sel = (row_i > 8'd3) ? 2'd0 : row_i[1:0];
  assign addr    = lcdseq_pkg::row_base(row_sel) + column_i;

  // Classify the request.
  always_comb begin
    job_o = '0;
    case (cmd_i)
      lcdseq_pkg::CMD_INIT: begin
        job_o.is_init    = 1'b1;
        job_o.rs         = 1'b0;
        job_o.data       = lcdseq_pkg::LCD_CLR_DISP;
        job_o.final_hold = lcdseq_pkg::HOLD_CLEAR;
      end
      lcdseq_pkg::CMD_CLEAR: begin
        job_o.is_init    = 1'b0;
        job_o.rs         = 1'b0;
        job_o.data       = lcdseq_pkg::LCD_CLR_DISP;
        job_o.final_hold = lcdseq_pkg::HOLD_CLEAR;
      end
      lcdseq_pkg::CMD_CURSOR: begin
        job_o.is_init    = 1'b0;
        job_o.rs         = 1'b0;
        job_o.data       = lcdseq_pkg::LCD_SET_DDRAM | addr;
        job_o.final_hold = lcdseq_pkg::HOLD_CMD;
      end
      default: begin
        job_o.is_init    = 1'b0;
        job_o.rs         = 1'b1;
        job_o.data       = character_i;
        job_o.final_hold = lcdseq_pkg::HOLD_DATA;
      end
    endcase
  end

endmodule

// File: rtl/lcdseq_queue.sv
// Two-entry job queue between the front end and the sequencer.
module lcdseq_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  lcdseq_pkg::job_t        job_i,
  output logic                    full_o,
  input  logic                    pop_i,
  output logic                    valid_o,
  output lcdseq_pkg::job_t        job_o
);

  lcdseq_pkg::job_t entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign job_o   = entry_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// File: rtl/lcdseq_back.sv
// Back end: steps through the pin states of each job into the output register.
module lcdseq_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    job_valid_i,
  input  lcdseq_pkg::job_t        job_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output lcdseq_pkg::pin_t        pin_o
);

  lcdseq_pkg::job_t cur_q, cur_d;
  logic             busy_q, busy_d;
  logic [4:0]       step_q, step_d;
  logic             out_valid_q;
  lcdseq_pkg::pin_t pin_q;
  logic [3:0]       lines_q;
  logic             select_q;
  lcdseq_pkg::pin_t pin_now;
  logic             adv;
  logic             emit;

  // The output register takes a new state when empty or being drained.
  assign adv  = !out_valid_q || !out_stall_i;
  assign emit = busy_q && adv;

  // Pin state for the current step.
  always_comb begin
    pin_now = '0;
    if (cur_q.is_init) begin
      if (step_q == 5'd0) begin
        pin_now.rs     = select_q;
        pin_now.en     = 1'b0;
        pin_now.nibble = lines_q;
        pin_now.hold   = lcdseq_pkg::HOLD_POWERUP;
        pin_now.last   = 1'b0;
      end else begin
        pin_now = lcdseq_pkg::init_pin(step_q);
      end
    end else begin
      pin_now.rs     = cur_q.rs;
      pin_now.en     = ~step_q[0];
      pin_now.nibble = step_q[1] ? cur_q.data[3:0] : cur_q.data[7:4];
      pin_now.last   = (step_q[1:0] == 2'd3);
      pin_now.hold   = pin_now.last ? cur_q.final_hold : lcdseq_pkg::HOLD_PULSE;
    end
  end

  // Take the next job when idle or when the current one finishes.
  assign pop_o = job_valid_i && (!busy_q || (emit && pin_now.last));

  always_comb begin
    cur_d  = cur_q;
    busy_d = busy_q;
    step_d = step_q;
    if (pop_o) begin
      cur_d  = job_i;
      busy_d = 1'b1;
      step_d = 5'd0;
    end else if (emit) begin
      if (pin_now.last) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= 5'd0;
      out_valid_q <= 1'b0;
      lines_q     <= 4'd0;
      select_q    <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      if (adv) begin
        out_valid_q <= busy_q;
      end
      // Track the levels last driven on the data and select lines.
      if (emit) begin
        lines_q  <= pin_now.nibble;
        select_q <= pin_now.rs;
      end
    end
  end

  // Job and output payload registers.
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (emit) begin
      pin_q <= pin_now;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pin_o       = pin_q;

endmodule

// File: rtl/lcdseq_checker.sv
// Port-level checks for the LCD bus sequencer, bound to the top level.
module lcdseq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       rs_o,
  input logic       en_o,
  input logic [3:0] nibble_o,
  input logic [5:0] hold_ms_o,
  input logic       last_o
);

  // A stalled result holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(nibble_o) && $stable(hold_ms_o)
      && $stable(rs_o) && $stable(en_o) && $stable(last_o))
    else $error("stalled result changed");

  // An enable pulse state is held one millisecond and never ends a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && en_o |-> hold_ms_o == 6'd1 && !last_o)
    else $error("enable pulse state malformed");

  // An enable pulse is followed at once by the settle state on the same lines.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && en_o |=> out_valid_o && !en_o
      && nibble_o == $past(nibble_o) && rs_o == $past(rs_o))
    else $error("enable pulse not followed by settle state");

  // No pin state carries a zero hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hold_ms_o != 6'd0)
    else $error("zero hold time");

endmodule

bind char_lcd_4bit_bus_sequencer_unit lcdseq_checker u_lcdseq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .rs_o        (rs_o),
  .en_o        (en_o),
  .nibble_o    (nibble_o),
  .hold_ms_o   (hold_ms_o),
  .last_o      (last_o)
);

// File: tb/sv/lcd_pin_checker.sv
// Checker that predicts the LCD pin states for each request and compares them with the block.
`timescale 1ns / 100ps

module lcd_pin_checker
  import lcdseq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [1:0] cmd_i,
  input  logic [7:0] character_i,
  input  logic [7:0] column_i,
  input  logic [7:0] row_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       rs_i,
  input  logic       en_i,
  input  logic [3:0] nibble_i,
  input  logic [5:0] hold_ms_i,
  input  logic       last_i,
  output int         mismatches_o,
  output int         pending_o
);

  // Pin states still owed by the block, oldest first.
  pin_t expected_pins[$];
  pin_t want;

  // Levels last driven on RS and D4..D7 as the predictor sees them.
  logic       line_rs;
  logic [3:0] line_nibble;

  // Print a mismatch and count it.
  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches_o++;
  endtask

  // Queue one pin state and track the line levels it leaves behind.
  task automatic queue_pin(input logic rs, input logic en, input logic [3:0] nib,
                           input logic [5:0] hold, input logic fin);
    pin_t p;
    p.rs = rs;
    p.en = en;
    p.nibble = nib;
    p.hold = hold;
    p.last = fin;
    expected_pins.push_back(p);
    line_rs = rs;
    line_nibble = nib;
  endtask

  // A nibble is an enable pulse followed by a settle state with the given hold.
  task automatic queue_nibble(input logic rs, input logic [3:0] nib,
                              input logic [5:0] settle, input logic fin);
    queue_pin(rs, 1'b1, nib, HOLD_PULSE, 1'b0);
    queue_pin(rs, 1'b0, nib, settle, fin);
  endtask

  // A byte goes out high nibble first; only the low nibble carries the final hold.
  task automatic queue_byte(input logic rs, input logic [7:0] value,
                            input logic [5:0] settle, input logic fin);
    queue_nibble(rs, value[7:4], HOLD_PULSE, 1'b0);
    queue_nibble(rs, value[3:0], settle, fin);
  endtask

  // Work out every pin state that one request produces.
  task automatic predict_request(input logic [1:0] cmd, input logic [7:0] ch,
                                 input logic [7:0] col, input logic [7:0] row);
    logic [7:0] row_start;
    logic [7:0] ddram_addr;
    case (cmd)
      CMD_INIT: begin
        // Power-up wait keeps whatever the lines held before.
        queue_pin(line_rs, 1'b0, line_nibble, HOLD_POWERUP, 1'b0);
        queue_nibble(1'b0, WAKE_NIB_A, HOLD_WAKE1, 1'b0);
        queue_nibble(1'b0, WAKE_NIB_A, HOLD_WAKE, 1'b0);
        queue_nibble(1'b0, WAKE_NIB_A, HOLD_WAKE, 1'b0);
        queue_nibble(1'b0, WAKE_NIB_B, HOLD_WAKE, 1'b0);
        queue_byte(1'b0, LCD_FUNC_SET, HOLD_CMD, 1'b0);
        queue_byte(1'b0, LCD_DISP_ON, HOLD_CMD, 1'b0);
        queue_byte(1'b0, LCD_ENTRY, HOLD_CMD, 1'b0);
        queue_byte(1'b0, LCD_CLR_DISP, HOLD_CLEAR, 1'b1);
      end
      CMD_CLEAR: begin
        queue_byte(1'b0, LCD_CLR_DISP, HOLD_CLEAR, 1'b1);
      end
      CMD_CURSOR: begin
        // Rows beyond the fourth fall back to the first row.
        case (row)
          8'd1:    row_start = 8'h40;
          8'd2:    row_start = 8'h14;
          8'd3:    row_start = 8'h54;
          default: row_start = 8'h00;
        endcase
        ddram_addr = row_start + col;
        queue_byte(1'b0, LCD_SET_DDRAM | ddram_addr, HOLD_CMD, 1'b1);
      end
      default: begin
        queue_byte(1'b1, ch, HOLD_DATA, 1'b1);
      end
    endcase
  endtask

  // Predict on each accepted request, compare on each accepted pin state.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_pins.delete();
      line_rs = 1'b0;
      line_nibble = 4'h0;
      mismatches_o = 0;
      pending_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        predict_request(cmd_i, character_i, column_i, row_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_pins.size() == 0) begin
          report_mismatch($sformatf("pin state with none expected: rs=%0b en=%0b nib=%h hold=%0d",
                                    rs_i, en_i, nibble_i, hold_ms_i));
        end else begin
          want = expected_pins.pop_front();
          if (rs_i !== want.rs) begin
            report_mismatch($sformatf("rs got %b want %b", rs_i, want.rs));
          end
          if (en_i !== want.en) begin
            report_mismatch($sformatf("en got %b want %b", en_i, want.en));
          end
          if (nibble_i !== want.nibble) begin
            report_mismatch($sformatf("nibble got %h want %h", nibble_i, want.nibble));
          end
          if (hold_ms_i !== want.hold) begin
            report_mismatch($sformatf("hold_ms got %0d want %0d", hold_ms_i, want.hold));
          end
          if (last_i !== want.last) begin
            report_mismatch($sformatf("last got %b want %b", last_i, want.last));
          end
        end
      end
      pending_o = expected_pins.size();
    end
  end

endmodule

// File: tb/sv/testbench.sv
// Top of the testbench: clock, reset, request stimulus, output stalls and the verdict.
`timescale 1ns / 100ps

module testbench;
  import lcdseq_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] cmd_i;
  logic [7:0] character_i;
  logic [7:0] column_i;
  logic [7:0] row_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       rs_o;
  logic       en_o;
  logic [3:0] nibble_o;
  logic [5:0] hold_ms_o;
  logic       last_o;

  int mismatches;
  int pending;
  int accepted;
  int burst_left;
  bit held_off;

  char_lcd_4bit_bus_sequencer_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .character_i (character_i),
    .column_i    (column_i),
    .row_i       (row_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rs_o        (rs_o),
    .en_o        (en_o),
    .nibble_o    (nibble_o),
    .hold_ms_o   (hold_ms_o),
    .last_o      (last_o)
  );

  lcd_pin_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .cmd_i        (cmd_i),
    .character_i  (character_i),
    .column_i     (column_i),
    .row_i        (row_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .rs_i         (rs_o),
    .en_i         (en_o),
    .nibble_i     (nibble_o),
    .hold_ms_i    (hold_ms_o),
    .last_i       (last_o),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // 10 ns clock.
  initial begin
    clk_i = 1'b0;
  end
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offer one request and wait until it is taken; gaps fall between bursts.
  task automatic send_request(input logic [1:0] cmd, input logic [7:0] ch,
                              input logic [7:0] col, input logic [7:0] row);
    int gap;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    character_i <= ch;
    column_i <= col;
    row_i <= row;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
    accepted++;
  endtask

  // Random request: mostly characters and cursor moves, rows mostly in range.
  task automatic send_random_request();
    int pick;
    logic [1:0] cmd;
    logic [7:0] col;
    logic [7:0] row;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      cmd = CMD_INIT;
    end else if (pick < 24) begin
      cmd = CMD_CLEAR;
    end else if (pick < 50) begin
      cmd = CMD_CURSOR;
    end else begin
      cmd = CMD_WRITE;
    end
    col = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 39)) : 8'($urandom_range(0, 255));
    row = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
    send_request(cmd, 8'($urandom_range(0, 255)), col, row);
  endtask

  // Reset, directed requests, random requests, then drain and judge.
  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = CMD_INIT;
    character_i = 8'h00;
    column_i = 8'h00;
    row_i = 8'h00;
    accepted = 0;
    burst_left = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Initialise straight out of reset sees all lines low.
    send_request(CMD_INIT, 8'($urandom), 8'($urandom), 8'($urandom));
    send_request(CMD_WRITE, 8'h00, 8'($urandom), 8'($urandom));
    send_request(CMD_WRITE, 8'hFF, 8'($urandom), 8'($urandom));
    // Power-up wait after data keeps RS high and the last nibble.
    send_request(CMD_INIT, 8'($urandom), 8'($urandom), 8'($urandom));
    send_request(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
    send_request(CMD_CURSOR, 8'($urandom), 8'h00, 8'd0);
    send_request(CMD_CURSOR, 8'($urandom), 8'h27, 8'd1);
    send_request(CMD_CURSOR, 8'($urandom), 8'h13, 8'd2);
    // Address wraps past 0xFF.
    send_request(CMD_CURSOR, 8'($urandom), 8'hFF, 8'd3);
    send_request(CMD_CURSOR, 8'($urandom), 8'hC0, 8'd1);
    // Out-of-range rows fall back to row zero.
    send_request(CMD_CURSOR, 8'($urandom), 8'h05, 8'd4);
    send_request(CMD_CURSOR, 8'($urandom), 8'hFF, 8'd255);
    send_request(CMD_INIT, 8'($urandom), 8'($urandom), 8'($urandom));
    send_request(CMD_WRITE, 8'hA5, 8'($urandom), 8'($urandom));
    send_request(CMD_WRITE, 8'h5A, 8'($urandom), 8'($urandom));
    send_request(CMD_CURSOR, 8'($urandom), 8'h80, 8'd0);
    send_request(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
    send_request(CMD_INIT, 8'($urandom), 8'($urandom), 8'($urandom));
    send_request(CMD_WRITE, 8'($urandom), 8'($urandom), 8'($urandom));

    repeat (241) send_random_request();
    in_valid_i <= 1'b0;

    // Wait for every pin state, then let any stray pin state show before the verdict.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS char_lcd_4bit_bus_sequencer_unit");
    end else begin
      $display("FAIL char_lcd_4bit_bus_sequencer_unit");
    end
    $finish;
  end

  // Output stalls follow a random pattern, picked anew for each stretch; one long hold-off fills the queue.
  initial begin
    int stall_mode;
    held_off = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held_off && accepted >= 80) begin
        held_off = 1'b1;
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
      end
      stall_mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 80)) begin
        case (stall_mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ~out_stall_i;
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Give up if the run hangs.
  initial begin
    #2000000;
    $display("FAIL char_lcd_4bit_bus_sequencer_unit");
    $finish;
  end

endmodule
